// ===== hdl/lsb_first_bit_packer_defines.svh =====
// assertion macros for the lsb first bit packer
// used by the front, queue and back modules; no dependencies
`ifndef LSB_FIRST_BIT_PACKER_DEFINES_SVH
`define LSB_FIRST_BIT_PACKER_DEFINES_SVH

`ifndef SYNTH
// property must hold at every clock edge outside reset
`define LBP_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("lbp check failed");
// expression must never be true outside reset
`define LBP_ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("lbp forbidden condition");
`else
`define LBP_ASSERT(lbl, clk, rstn, prop)
`define LBP_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif

`endif

// ===== hdl/lbp_pkg.sv =====
// shared constants and types of the lsb first bit packer
// no dependencies
`default_nettype none

package lbp_pkg;

    localparam int LBP_MAX_FIELD_BITS = 32;
    localparam int LBP_FW_W           = 6;
    localparam int LBP_PEND_W         = 7;
    localparam int LBP_CNT_W          = 3;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_FLUSH = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    typedef struct packed {
        logic [LBP_CNT_W-1:0] nbytes;
        logic                 stream_end;
    } t_job_ctrl;

endpackage

`default_nettype wire

// ===== hdl/lsb_first_bit_packer.sv =====
// lsb first bit packer: packs 0 to 32 bit fields into a byte stream
// top level; depends on lbp_pkg, lbp_front, lbp_queue and lbp_back
//
// input channel (i_in_valid / o_in_ready) takes one command item:
//   write appends the low i_field_width bits of i_field_value, lsb first
//   flush emits the partial byte zero padded, marked with o_stream_end
//   clear drops the pending bits; unused command codes are ignored
// output channel (o_out_valid / i_out_ready) gives one byte per item;
//   o_run_last marks the last byte caused by one input item
// the job of an item enters the queue at the edge that accepts it, and its
//   first byte moves on into the output register when the output side is free
// the byte output register moves one byte a cycle while the receiver does not
//   stall, and an item completes up to 4 bytes; the front takes an item every
//   cycle while the two-entry job queue has room
// reset clears the pending bits, the queue and the valid flag of the output register
// a receiver stall holds the byte on the output ports; the queue then
//   fills and o_in_ready drops until the back end moves again
`default_nettype none

module lsb_first_bit_packer
    import lbp_pkg::*;
#(
    parameter int MAX_FIELD_BITS = LBP_MAX_FIELD_BITS
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic [1:0]          i_command,
    input  wire logic [31:0]         i_field_value,
    input  wire logic [LBP_FW_W-1:0] i_field_width,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic [7:0]               o_packed_byte,
    output logic                     o_run_last,
    output logic                     o_stream_end
);

    // widest job: pending bits plus a full field, in whole bytes
    localparam int DATA_W = ((MAX_FIELD_BITS + LBP_PEND_W) / 8) * 8;

    logic              w_q_ready;
    logic              w_push;
    logic [DATA_W-1:0] w_push_data;
    t_job_ctrl         w_push_ctrl;
    logic              w_q_valid;
    logic [DATA_W-1:0] w_q_data;
    t_job_ctrl         w_q_ctrl;
    logic              w_pop;

    // classify the item and update the partial byte
    lbp_front #(
        .MAX_FIELD_BITS (MAX_FIELD_BITS),
        .DATA_W         (DATA_W)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (i_command),
        .i_field_value (i_field_value),
        .i_field_width (i_field_width),
        .i_q_ready     (w_q_ready),
        .o_push        (w_push),
        .o_job_data    (w_push_data),
        .o_job_ctrl    (w_push_ctrl)
    );

    // jobs of completed bytes waiting for the output side
    lbp_queue #(
        .DATA_W (DATA_W)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_push_ctrl (w_push_ctrl),
        .o_ready     (w_q_ready),
        .o_valid     (w_q_valid),
        .o_data      (w_q_data),
        .o_ctrl      (w_q_ctrl),
        .i_pop       (w_pop)
    );

    // serialize each job into bytes
    lbp_back #(
        .DATA_W (DATA_W)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_q_valid),
        .i_q_data      (w_q_data),
        .i_q_ctrl      (w_q_ctrl),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_packed_byte (o_packed_byte),
        .o_run_last    (o_run_last),
        .o_stream_end  (o_stream_end)
    );

endmodule

`default_nettype wire

// ===== hdl/lbp_front.sv =====
// front end: accepts items, keeps the partial byte, builds byte jobs
// depends on lbp_pkg and lsb_first_bit_packer_defines.svh
`default_nettype none
`include "lsb_first_bit_packer_defines.svh"

module lbp_front
    import lbp_pkg::*;
#(
    parameter int MAX_FIELD_BITS = LBP_MAX_FIELD_BITS,
    parameter int DATA_W         = ((MAX_FIELD_BITS + 7) / 8) * 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [1:0]            i_command,
    input  wire logic [31:0]           i_field_value,
    input  wire logic [LBP_FW_W-1:0]   i_field_width,
    input  wire logic                  i_q_ready,
    output logic                       o_push,
    output logic [DATA_W-1:0]          o_job_data,
    output t_job_ctrl                  o_job_ctrl
);

    localparam int ACC_W = MAX_FIELD_BITS + LBP_PEND_W;
    localparam int TOT_W = $clog2(ACC_W + 1);

    logic [LBP_PEND_W-1:0]     r_pend_bits, n_pend_bits;
    logic [LBP_CNT_W-1:0]      r_pend_cnt,  n_pend_cnt;

    logic                      w_accept;
    logic [LBP_FW_W-1:0]       w_width;
    logic [MAX_FIELD_BITS-1:0] w_val;
    logic [ACC_W-1:0]          w_acc;
    logic [ACC_W-1:0]          w_rest;
    logic [TOT_W-1:0]          w_total;
    logic [TOT_W-1:0]          w_shift;

    assign o_in_ready = i_q_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    // saturate the width, then keep only the low width bits
    assign w_width = (i_field_width > LBP_FW_W'(MAX_FIELD_BITS))
                   ? LBP_FW_W'(MAX_FIELD_BITS) : i_field_width;

    always_comb begin
        for (int i = 0; i < MAX_FIELD_BITS; i++) begin
            w_val[i] = i_field_value[i] && (LBP_FW_W'(i) < w_width);
        end
    end

    assign w_acc   = (ACC_W'(w_val) << r_pend_cnt) | ACC_W'(r_pend_bits);
    assign w_total = TOT_W'(r_pend_cnt) + TOT_W'(w_width);
    assign w_shift = {w_total[TOT_W-1:3], 3'b000};
    assign w_rest  = w_acc >> w_shift;

    always_comb begin
        n_pend_bits = r_pend_bits;
        n_pend_cnt  = r_pend_cnt;
        o_push      = 1'b0;
        o_job_data  = w_acc[DATA_W-1:0];
        o_job_ctrl  = '{nbytes: LBP_CNT_W'(w_total >> 3), stream_end: 1'b0};
        if (w_accept) begin
            unique case (i_command)
                CMD_WRITE: begin
                    if (w_width != '0) begin
                        o_push      = (w_total[TOT_W-1:3] != '0);
                        n_pend_cnt  = w_total[2:0];
                        n_pend_bits = w_rest[LBP_PEND_W-1:0];
                    end
                end
                CMD_FLUSH: begin
                    o_job_data  = DATA_W'(r_pend_bits);
                    o_job_ctrl  = '{nbytes: LBP_CNT_W'(1), stream_end: 1'b1};
                    o_push      = (r_pend_cnt != '0);
                    n_pend_bits = '0;
                    n_pend_cnt  = '0;
                end
                CMD_CLEAR: begin
                    n_pend_bits = '0;
                    n_pend_cnt  = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_bits <= '0;
            r_pend_cnt  <= '0;
        end else begin
            r_pend_bits <= n_pend_bits;
            r_pend_cnt  <= n_pend_cnt;
        end
    end

    // bits above the pending count stay zero
    `LBP_ASSERT(a_pend_clean, i_clk, i_rst_n, (r_pend_bits >> r_pend_cnt) == '0)

endmodule

`default_nettype wire

// ===== hdl/lbp_queue.sv =====
// two-entry job queue between front and back
// depends on lbp_pkg and lsb_first_bit_packer_defines.svh
`default_nettype none
`include "lsb_first_bit_packer_defines.svh"

module lbp_queue
    import lbp_pkg::*;
#(
    parameter int DATA_W = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [DATA_W-1:0] i_push_data,
    input  wire t_job_ctrl         i_push_ctrl,
    output logic                   o_ready,
    output logic                   o_valid,
    output logic [DATA_W-1:0]      o_data,
    output t_job_ctrl              o_ctrl,
    input  wire logic              i_pop
);

    logic [DATA_W-1:0] r_data [2];
    t_job_ctrl         r_ctrl [2];
    logic              r_wr_ptr, r_rd_ptr;
    logic [1:0]        r_cnt;
    logic              w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_data[r_rd_ptr];
    assign o_ctrl  = r_ctrl[r_rd_ptr];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_data[r_wr_ptr] <= i_push_data;
            r_ctrl[r_wr_ptr] <= i_push_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (w_push) r_wr_ptr <= !r_wr_ptr;
            if (w_pop)  r_rd_ptr <= !r_rd_ptr;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    `LBP_ASSERT_NEVER(a_push_full, i_clk, i_rst_n, i_push && !o_ready)
    `LBP_ASSERT_NEVER(a_cnt_range, i_clk, i_rst_n, r_cnt == 2'd3)

endmodule

`default_nettype wire

// ===== hdl/lbp_back.sv =====
// back end: unrolls byte jobs into the output register, one byte a cycle while the receiver takes it
// depends on lbp_pkg and lsb_first_bit_packer_defines.svh
`default_nettype none
`include "lsb_first_bit_packer_defines.svh"

module lbp_back
    import lbp_pkg::*;
#(
    parameter int DATA_W = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_valid,
    input  wire logic [DATA_W-1:0] i_q_data,
    input  wire t_job_ctrl         i_q_ctrl,
    output logic                   o_pop,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [7:0]             o_packed_byte,
    output logic                   o_run_last,
    output logic                   o_stream_end
);

    logic [DATA_W-1:0]    r_data, n_data;
    logic [LBP_CNT_W-1:0] r_left, n_left;
    logic                 r_end,  n_end;
    logic                 r_ovalid, n_ovalid;
    logic [7:0]           r_byte, n_byte;
    logic                 r_last, n_last;
    logic                 r_oend, n_oend;
    logic                 w_adv;

    assign w_adv         = !r_ovalid || i_out_ready;
    assign o_pop         = w_adv && (r_left == '0) && i_q_valid;
    assign o_out_valid   = r_ovalid;
    assign o_packed_byte = r_byte;
    assign o_run_last    = r_last;
    assign o_stream_end  = r_oend;

    always_comb begin
        n_data   = r_data;
        n_left   = r_left;
        n_end    = r_end;
        n_ovalid = r_ovalid;
        n_byte   = r_byte;
        n_last   = r_last;
        n_oend   = r_oend;
        if (w_adv) begin
            priority if (r_left != '0) begin
                n_byte   = r_data[7:0];
                n_data   = r_data >> 8;
                n_left   = r_left - LBP_CNT_W'(1);
                n_last   = (r_left == LBP_CNT_W'(1));
                n_oend   = r_end;
                n_ovalid = 1'b1;
            end else if (i_q_valid) begin
                n_byte   = i_q_data[7:0];
                n_data   = i_q_data >> 8;
                n_left   = i_q_ctrl.nbytes - LBP_CNT_W'(1);
                n_end    = i_q_ctrl.stream_end;
                n_last   = (i_q_ctrl.nbytes == LBP_CNT_W'(1));
                n_oend   = i_q_ctrl.stream_end;
                n_ovalid = 1'b1;
            end else begin
                n_ovalid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_end  <= n_end;
        r_byte <= n_byte;
        r_last <= n_last;
        r_oend <= n_oend;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_left   <= n_left;
            r_ovalid <= n_ovalid;
        end
    end

    // bytes still owed by a job means a byte sits in the output register
    `LBP_ASSERT(a_left_has_out, i_clk, i_rst_n, (r_left == '0) || r_ovalid)

endmodule

`default_nettype wire
